// ----- rtl/byte_budget_fifo_packer_defines.svh -----
// Assertion macros for the byte budget FIFO packer.
// Needs clk_i and rst_ni in the scope of the including module.
`ifndef BYTE_BUDGET_FIFO_PACKER_DEFINES_SVH
`define BYTE_BUDGET_FIFO_PACKER_DEFINES_SVH
`ifndef SYNTHESIS
`define BBFP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define BBFP_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define BBFP_ASSERT(name, prop, msg)
`define BBFP_NEVER(name, cond, msg)
`endif
`endif

// ----- rtl/bbfp_pkg.sv -----
// Package of the byte budget FIFO packer: sizes, register indexes, state and payload types.
// Used by byte_budget_fifo_packer; depends on nothing else.
`timescale 1ns / 1ps
package bbfp_pkg;

  localparam int unsigned QUEUE_DEPTH = 4096;
  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

  localparam int unsigned IN_DATA_W = 48;
  localparam int unsigned OUT_DATA_W = 240;
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAPACITY = 2'd0,
    REG_BUDGET   = 2'd1,
    REG_WARMUP   = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ARRIVE,
    ST_DRAIN
  } state_e;

  typedef struct packed {
    logic [31:0] event_time;
    logic [15:0] item_size;
  } in_data_t;

  typedef struct packed {
    logic        pad;
    logic [31:0] drops_counted;
    logic [31:0] arrivals_counted;
    logic [31:0] blocks_seen;
    logic [31:0] peak_occupancy;
    logic [31:0] occupancy;
    logic        counted;
    logic [31:0] interval;
    logic [31:0] packed_bytes;
    logic [11:0] packed_count;
    logic        store_full_error;
    logic        accepted;
  } out_data_t;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    next_ptr = (p == LAST_PTR) ? '0 : p + PTR_W'(1);
  endfunction

endpackage

// ----- rtl/byte_budget_fifo_packer.sv -----
// Byte budget FIFO packer top level: size store, shared 33-bit add and compare, sequencer.
// Depends on bbfp_pkg and byte_budget_fifo_packer_defines.svh.
//
// Channel  Direction  Handshake                 Content
// s_axis   in         tvalid / tready           tuser: op; tdata: item_size, event_time
// m_axis   out        tvalid / tready           tuser: result_kind; tdata: result fields
// cfg      in         cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// An arrival is a transfer in the idle state, then the byte check and store write in the arrive step.
// A block event is a transfer, then one pop per fitting head entry, then the result; the
// single add and compare unit checks one head entry per cycle against the block budget.
// The block takes no input until its result is loaded into the output register.
// A stalled output holds the sequencer in its last step. Reset needs no clearing pass.
`timescale 1ns / 1ps
`include "byte_budget_fifo_packer_defines.svh"
module byte_budget_fifo_packer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // Fields from bit 0: item_size[15:0], event_time[47:16].
  input  logic [bbfp_pkg::IN_DATA_W-1:0] s_axis_tdata,
  // Field: op.
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // Fields from bit 0: accepted, store_full_error, packed_count, packed_bytes, interval,
  // counted, occupancy, peak_occupancy, blocks_seen, arrivals_counted, drops_counted, zero.
  output logic [bbfp_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // Field: result_kind.
  output logic                          m_axis_tuser,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bbfp_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]                   cfg_data_i
);
  import bbfp_pkg::*;

  state_e state_q, state_d;
  logic [31:0] capacity_q, budget_q;
  logic [7:0] warmup_q;
  logic op_q, op_d;
  in_data_t in_q, in_d;
  logic [PTR_W-1:0] read_ptr_q, read_ptr_d, write_ptr_q, write_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [31:0] total_q, total_d, peak_q, peak_d, blocks_q, blocks_d;
  logic [31:0] prev_time_q, prev_time_d, arrivals_q, arrivals_d, drops_q, drops_d;
  logic [31:0] pbytes_q, pbytes_d;
  logic [11:0] pcount_q, pcount_d;
  logic m_valid_q, m_valid_d;
  logic m_kind_q, m_kind_d;
  out_data_t m_data_q, m_data_d;

  logic [15:0] size_mem [QUEUE_DEPTH];
  logic [15:0] head_q;
  logic wr_en;

  logic [31:0] op_a, op_limit;
  logic [15:0] op_b;
  logic [32:0] sum;
  logic fits, out_free, counted;

  assign op_a = (state_q == ST_DRAIN) ? pbytes_q : total_q;
  assign op_b = (state_q == ST_DRAIN) ? head_q : in_q.item_size;
  assign op_limit = (state_q == ST_DRAIN) ? budget_q : capacity_q;
  assign sum = {1'b0, op_a} + {17'b0, op_b};
  assign fits = (sum <= {1'b0, op_limit});
  assign out_free = !m_valid_q || m_axis_tready;

  always_comb begin
    state_d = state_q;
    op_d = op_q;
    in_d = in_q;
    read_ptr_d = read_ptr_q;
    write_ptr_d = write_ptr_q;
    count_d = count_q;
    total_d = total_q;
    peak_d = peak_q;
    blocks_d = blocks_q;
    prev_time_d = prev_time_q;
    arrivals_d = arrivals_q;
    drops_d = drops_q;
    pbytes_d = pbytes_q;
    pcount_d = pcount_q;
    m_kind_d = m_kind_q;
    m_data_d = m_data_q;
    m_valid_d = m_valid_q && !m_axis_tready;
    wr_en = 1'b0;
    counted = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          op_d = s_axis_tuser;
          in_d = in_data_t'(s_axis_tdata);
          pbytes_d = '0;
          pcount_d = '0;
          state_d = s_axis_tuser ? ST_DRAIN : ST_ARRIVE;
        end
      end
      ST_ARRIVE: begin
        if (out_free) begin
          counted = (blocks_q >= {24'b0, warmup_q});
          m_data_d = '0;
          if (counted) begin
            arrivals_d = arrivals_q + 32'd1;
          end
          if (fits) begin
            if (count_q == DEPTH_CNT) begin
              m_data_d.store_full_error = 1'b1;
            end else begin
              wr_en = 1'b1;
              write_ptr_d = next_ptr(write_ptr_q);
              count_d = count_q + CNT_W'(1);
              total_d = sum[31:0];
              m_data_d.accepted = 1'b1;
            end
          end else if (counted) begin
            drops_d = drops_q + 32'd1;
          end
          if (total_d > peak_q) begin
            peak_d = total_d;
          end
          m_data_d.counted = counted;
          m_data_d.occupancy = total_d;
          m_data_d.peak_occupancy = peak_d;
          m_data_d.blocks_seen = blocks_q;
          m_data_d.arrivals_counted = arrivals_d;
          m_data_d.drops_counted = drops_d;
          m_kind_d = 1'b0;
          m_valid_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_DRAIN: begin
        if (count_q != '0 && fits) begin
          read_ptr_d = next_ptr(read_ptr_q);
          count_d = count_q - CNT_W'(1);
          pbytes_d = sum[31:0];
          total_d = total_q - {16'b0, head_q};
          if (pcount_q != 12'hFFF) begin
            pcount_d = pcount_q + 12'd1;
          end
        end else if (out_free) begin
          blocks_d = blocks_q + 32'd1;
          prev_time_d = in_q.event_time;
          counted = (blocks_d > {24'b0, warmup_q});
          m_data_d = '0;
          m_data_d.packed_count = pcount_q;
          m_data_d.packed_bytes = pbytes_q;
          m_data_d.interval = in_q.event_time - prev_time_q;
          m_data_d.counted = counted;
          m_data_d.occupancy = total_q;
          m_data_d.peak_occupancy = peak_q;
          m_data_d.blocks_seen = blocks_d;
          m_data_d.arrivals_counted = arrivals_q;
          m_data_d.drops_counted = drops_q;
          m_kind_d = 1'b1;
          m_valid_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      capacity_q <= 32'd300000000;
      budget_q <= 32'd1000000;
      warmup_q <= 8'd10;
      read_ptr_q <= '0;
      write_ptr_q <= '0;
      count_q <= '0;
      total_q <= '0;
      peak_q <= '0;
      blocks_q <= '0;
      prev_time_q <= '0;
      arrivals_q <= '0;
      drops_q <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      read_ptr_q <= read_ptr_d;
      write_ptr_q <= write_ptr_d;
      count_q <= count_d;
      total_q <= total_d;
      peak_q <= peak_d;
      blocks_q <= blocks_d;
      prev_time_q <= prev_time_d;
      arrivals_q <= arrivals_d;
      drops_q <= drops_d;
      m_valid_q <= m_valid_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          REG_CAPACITY: capacity_q <= cfg_data_i;
          REG_BUDGET:   budget_q <= cfg_data_i;
          REG_WARMUP:   warmup_q <= cfg_data_i[7:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d;
    in_q <= in_d;
    pbytes_q <= pbytes_d;
    pcount_q <= pcount_d;
    m_kind_q <= m_kind_d;
    m_data_q <= m_data_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      size_mem[write_ptr_q] <= in_q.item_size;
    end
    head_q <= size_mem[read_ptr_d];
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser = m_kind_q;
  assign m_axis_tdata = m_data_q;
  assign cfg_ready_o = 1'b1;

  `BBFP_NEVER(a_count_in_range, count_q > DEPTH_CNT, "Entry count exceeds the store depth.")
  `BBFP_NEVER(a_peak_tracks, total_q > peak_q, "Stored bytes exceed the recorded peak.")
  `BBFP_ASSERT(a_empty_no_bytes, (count_q == '0) |-> (total_q == '0), "Empty store holds bytes.")
  `BBFP_ASSERT(a_drain_budget, (state_q == ST_DRAIN && op_q) |-> (pbytes_q <= budget_q),
               "Drained bytes exceed the block budget.")

endmodule

// ----- test/testbench.sv -----
// Testbench of byte_budget_fifo_packer: directed and random arrivals and block drains,
// each result checked against a behavioral copy of the byte-budget FIFO held in a class.
// Depends on bbfp_pkg and the byte_budget_fifo_packer RTL.
`timescale 1ns / 1ps
module testbench;
  import bbfp_pkg::*;

  typedef struct packed {
    logic        pad;
    logic        kind;
    logic        accepted;
    logic        full_err;
    logic [11:0] count;
    logic [31:0] bytes;
    logic [31:0] interval;
    logic        counted;
    logic [31:0] occupancy;
    logic [31:0] peak;
    logic [31:0] blocks;
    logic [31:0] arrivals;
    logic [31:0] drops;
  } packer_result_t;

  class packer_tracker;
    bit [31:0] capacity;
    bit [31:0] budget;
    bit [7:0] warmup;
    bit [15:0] sizes [QUEUE_DEPTH];
    int unsigned rd_idx;
    int unsigned wr_idx;
    int unsigned entries;
    bit [31:0] held_bytes;
    bit [31:0] peak_bytes;
    bit [31:0] blocks;
    bit [31:0] prev_stamp;
    bit [31:0] arrivals;
    bit [31:0] drops;
    packer_result_t results_due[$];
    int unsigned faults;

    function new();
      capacity = 32'd300000000;
      budget = 32'd1000000;
      warmup = 8'd10;
    endfunction

    function void set_reg(reg_idx_e idx, bit [31:0] value);
      case (idx)
        REG_CAPACITY: capacity = value;
        REG_BUDGET: budget = value;
        REG_WARMUP: warmup = value[7:0];
        default: ;
      endcase
    endfunction

    function void apply_event(bit op, bit [15:0] size, bit [31:0] now);
      packer_result_t r;
      bit [15:0] head;
      r = '0;
      r.kind = op;
      if (!op) begin
        r.counted = (blocks >= {24'd0, warmup});
        if (r.counted) arrivals = arrivals + 1;
        if ({1'b0, held_bytes} + size <= {1'b0, capacity}) begin
          if (entries >= QUEUE_DEPTH) begin
            r.full_err = 1'b1;
          end else begin
            sizes[wr_idx] = size;
            wr_idx = (wr_idx + 1) % QUEUE_DEPTH;
            entries = entries + 1;
            held_bytes = held_bytes + size;
            if (held_bytes > peak_bytes) peak_bytes = held_bytes;
            r.accepted = 1'b1;
          end
        end else if (r.counted) begin
          drops = drops + 1;
        end
      end else begin
        r.interval = now - prev_stamp;
        prev_stamp = now;
        while (entries > 0) begin
          head = sizes[rd_idx];
          if ({1'b0, r.bytes} + head > {1'b0, budget}) break;
          rd_idx = (rd_idx + 1) % QUEUE_DEPTH;
          entries = entries - 1;
          r.bytes = r.bytes + head;
          held_bytes = held_bytes - head;
          if (r.count != 12'hFFF) r.count = r.count + 12'd1;
        end
        blocks = blocks + 1;
        r.counted = (blocks > {24'd0, warmup});
      end
      r.occupancy = held_bytes;
      r.peak = peak_bytes;
      r.blocks = blocks;
      r.arrivals = arrivals;
      r.drops = drops;
      results_due.push_back(r);
    endfunction

    function string describe(packer_result_t r);
      return {$sformatf("kind %0b acc %0b err %0b count %0d bytes %0d interval %0d",
                        r.kind, r.accepted, r.full_err, r.count, r.bytes, r.interval),
              $sformatf(" counted %0b occ %0d peak %0d blocks %0d arr %0d drops %0d pad %0b",
                        r.counted, r.occupancy, r.peak, r.blocks, r.arrivals, r.drops,
                        r.pad)};
    endfunction

    function void match_result(logic kind, logic [OUT_DATA_W-1:0] data);
      out_data_t got;
      packer_result_t seen;
      packer_result_t want;
      got = data;
      seen.pad = got.pad;
      seen.kind = kind;
      seen.accepted = got.accepted;
      seen.full_err = got.store_full_error;
      seen.count = got.packed_count;
      seen.bytes = got.packed_bytes;
      seen.interval = got.interval;
      seen.counted = got.counted;
      seen.occupancy = got.occupancy;
      seen.peak = got.peak_occupancy;
      seen.blocks = got.blocks_seen;
      seen.arrivals = got.arrivals_counted;
      seen.drops = got.drops_counted;
      if (results_due.size() == 0) begin
        faults++;
        if (faults <= 10) $display("unexpected result: %s", describe(seen));
        return;
      end
      want = results_due.pop_front();
      if (seen !== want) begin
        faults++;
        if (faults <= 10) begin
          $display("mismatch, expected: %s", describe(want));
          $display("           actual: %s", describe(seen));
        end
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata;
  logic s_axis_tuser;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic m_axis_tuser;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [31:0] cfg_data_i;

  packer_tracker tracker = new();
  bit send_idle;
  bit recv_idle;
  bit [31:0] ticks;

  byte_budget_fifo_packer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  initial begin
    #(64'd10_000_000);
    $display("testbench: FAIL");
    $finish;
  end

  task automatic send_item(input bit op, input bit [15:0] size, input bit [31:0] now);
    int unsigned gap;
    gap = send_idle ? $urandom_range(0, 9) : 0;
    @(negedge clk_i);
    repeat (gap) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser = op;
    s_axis_tdata = {now, size};
    do @(posedge clk_i); while (!s_axis_tready);
    tracker.apply_event(op, size, now);
  endtask

  task automatic wait_quiet();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (tracker.results_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input bit [31:0] value);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    tracker.set_reg(idx, value);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic bit [15:0] pick_size();
    case ($urandom_range(0, 7))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom);
      default: return 16'($urandom_range(1, 2000));
    endcase
  endfunction

  initial begin
    int unsigned gap;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = recv_idle ? $urandom_range(0, 9) : 0;
      @(negedge clk_i);
      repeat (gap) begin
        m_axis_tready = 1'b0;
        @(negedge clk_i);
      end
      m_axis_tready = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      tracker.match_result(m_axis_tuser, m_axis_tdata);
    end
  end

  initial begin
    int unsigned i;
    int unsigned round;
    bit [31:0] v;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_CAPACITY;
    cfg_data_i = '0;
    send_idle = 1'b1;
    recv_idle = 1'b1;
    ticks = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_item(1'b0, 16'd1, 32'd0);
    send_item(1'b0, 16'hFFFF, 32'hFFFF_FFFF);
    send_item(1'b0, 16'd0, 32'h8000_0000);
    send_item(1'b1, 16'hFFFF, 32'hFFFF_FFFF);
    send_item(1'b1, 16'd0, 32'd3);
    send_item(1'b0, 16'h5A5A, 32'd7);
    send_item(1'b1, 16'h1234, 32'd10);

    wait_quiet();
    write_reg(REG_CAPACITY, 32'd1);
    write_reg(REG_BUDGET, 32'd1);
    write_reg(REG_WARMUP, 32'd0);
    send_item(1'b0, 16'd0, 32'd20);
    send_item(1'b0, 16'd1, 32'd21);
    send_item(1'b0, 16'd1, 32'd22);
    send_item(1'b0, 16'd0, 32'd23);
    send_item(1'b1, 16'd0, 32'd30);
    send_item(1'b1, 16'd0, 32'd30);

    wait_quiet();
    write_reg(REG_CAPACITY, 32'hFFFF_FFFF);
    send_item(1'b0, 16'hFFFF, 32'd40);
    send_item(1'b0, 16'd2, 32'd41);
    send_item(1'b1, 16'd0, 32'd50);
    wait_quiet();
    write_reg(REG_BUDGET, 32'd65535);
    send_item(1'b1, 16'd0, 32'd60);

    // Empty the store, refill a little, then set the byte limit to exactly the stored total.
    wait_quiet();
    write_reg(REG_BUDGET, 32'hFFFF_FFFF);
    write_reg(REG_WARMUP, 32'd255);
    send_idle = 1'b0;
    recv_idle = 1'b0;
    ticks = 32'd100;
    send_item(1'b1, 16'd0, ticks);
    for (i = 0; i < 8; i++) begin
      send_item(1'b0, 16'($urandom_range(0, 3)), ticks);
    end
    send_item(1'b0, 16'd7, ticks);
    wait_quiet();
    write_reg(REG_CAPACITY, tracker.held_bytes);
    send_item(1'b0, 16'd1, ticks);
    send_item(1'b0, 16'd0, ticks);
    send_item(1'b1, 16'd0, ticks + 32'd500);
    ticks = ticks + 32'd500;
    send_idle = 1'b1;
    recv_idle = 1'b1;

    for (round = 0; round < 5; round++) begin
      wait_quiet();
      case ($urandom_range(0, 2))
        0: v = $urandom_range(1000, 300000);
        1: v = $urandom;
        default: v = 32'hFFFF_FFFF;
      endcase
      if (v == 0) v = 32'd1;
      write_reg(REG_CAPACITY, v);
      case ($urandom_range(0, 3))
        0: v = $urandom_range(1, 4000);
        1: v = $urandom_range(4000, 200000);
        2: v = $urandom;
        default: v = 32'hFFFF_FFFF;
      endcase
      if (v == 0) v = 32'd1;
      write_reg(REG_BUDGET, v);
      if ($urandom_range(0, 3) == 0) begin
        v = $urandom_range(0, 255);
      end else begin
        v = tracker.blocks + $urandom_range(0, 40);
        if (v > 255) v = 32'd255;
      end
      write_reg(REG_WARMUP, v);
      send_idle = (round != 2);
      recv_idle = (round != 3);
      for (i = 0; i < 250; i++) begin
        if ($urandom_range(0, 99) == 0) wait_quiet();
        if ($urandom_range(0, 19) == 0) ticks = $urandom;
        else ticks = ticks + $urandom_range(0, 5000);
        send_item($urandom_range(0, 4) == 0, pick_size(), ticks);
      end
    end

    wait_quiet();
    repeat (10) @(posedge clk_i);
    if (tracker.faults == 0 && tracker.results_due.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end
endmodule
